@@ sv/apbi_pkg.sv @@
// Shared types and constants for the antenna PCV bilinear interpolator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package apbi_pkg;

    // shared restoring divider: numerator and denominator widths
    localparam int DIV_NW = 52;
    localparam int DIV_DW = 32;

    localparam int VAL_W = 16;
    localparam int OUT_W = 20;
    localparam int WGT_W = 18;
    localparam int ACC_W = 52;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sd524287;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -20'sd524288;

    localparam logic [1:0] MODE_LOAD_ZEN  = 2'd0;
    localparam logic [1:0] MODE_LOAD_GRID = 2'd1;
    localparam logic [1:0] MODE_QUERY     = 2'd2;

    localparam logic [2:0] CFG_ZEN_START  = 3'd0;
    localparam logic [2:0] CFG_ZEN_STEP   = 3'd1;
    localparam logic [2:0] CFG_ZEN_POINTS = 3'd2;
    localparam logic [2:0] CFG_AZI_STEP   = 3'd3;
    localparam logic [2:0] CFG_AZI_POINTS = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZGO,
        ST_ZWAIT,
        ST_AGO,
        ST_AWAIT,
        ST_BASE,
        ST_WGT,
        ST_MAC,
        ST_QGO,
        ST_QWAIT,
        ST_SAT,
        ST_RES
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
        logic grid;
    } t_tbl_ctl;

endpackage

@@ sv/apbi_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on apbi_pkg for its widths.
`timescale 1ns / 1ps

module apbi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [apbi_pkg::DIV_NW-1:0] i_num,
    input  logic [apbi_pkg::DIV_DW-1:0] i_den,
    output logic                        o_done,
    output logic [apbi_pkg::DIV_NW-1:0] o_quot
);
    import apbi_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? DIV_DW'(trial - {1'b0, r_den}) : DIV_DW'(trial);
            r_quo <= {r_quo[DIV_NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && r_busy))
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without work");

endmodule

@@ sv/apbi_tables.sv @@
// PCV tables: grid memory and zenith-only memory, one shared port each.
// Depends on apbi_pkg for the control struct.
`timescale 1ns / 1ps

module apbi_tables #(
    parameter int ZW = 5,
    parameter int AW = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  apbi_pkg::t_tbl_ctl                i_ctl,
    input  logic                              i_f,
    input  logic [AW-1:0]                     i_row,
    input  logic [ZW-1:0]                     i_col,
    input  logic signed [apbi_pkg::VAL_W-1:0] i_wdata,
    output logic signed [apbi_pkg::VAL_W-1:0] o_rdata
);
    import apbi_pkg::*;

    localparam int GDEPTH = 2 ** (1 + AW + ZW);
    localparam int ZDEPTH = 2 ** (1 + ZW);

    logic signed [VAL_W-1:0] mem_grid [GDEPTH];
    logic signed [VAL_W-1:0] mem_zen  [ZDEPTH];
    logic signed [VAL_W-1:0] r_rd_grid;
    logic signed [VAL_W-1:0] r_rd_zen;
    logic                    r_rsel;
    logic [AW+ZW:0]          gaddr;
    logic [ZW:0]             zaddr;

    assign gaddr = {i_f, i_row, i_col};
    assign zaddr = {i_f, i_col};

    always_ff @(posedge i_clk) begin
        if (i_ctl.we && i_ctl.grid) begin
            mem_grid[gaddr] <= i_wdata;
        end
        if (i_ctl.re && i_ctl.grid) begin
            r_rd_grid <= mem_grid[gaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we && !i_ctl.grid) begin
            mem_zen[zaddr] <= i_wdata;
        end
        if (i_ctl.re && !i_ctl.grid) begin
            r_rd_zen <= mem_zen[zaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rsel <= i_ctl.grid;
        end
    end

    assign o_rdata = r_rsel ? r_rd_grid : r_rd_zen;

    a_single_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.we && i_ctl.re))
        else $error("table read and write in the same cycle");

endmodule

@@ sv/antenna_pcv_bilinear_interp.sv @@
// Antenna phase-center-variation lookup with linear / bilinear interpolation.
// Depends on apbi_pkg, apbi_div and apbi_tables.
//
// Usage:
//  - Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 zen_start,
//    1 zen_step, 2 zen_points, 3 azi_step, 4 azi_points. Write only when idle.
//  - Input channel (i_in_valid / o_in_ready): mode 0 loads a zenith-only entry,
//    mode 1 a grid entry, mode 2 is a query; mode 3 is dropped. A load gives
//    no result. A query gives one output transaction.
//  - A query runs as a sequence: a zenith cell-index division, an azimuth one
//    (grid mode only), then per frequency up to four table reads into a
//    multiply-accumulate pipe and a rounded division of the sum by the sum of
//    the weights. All divisions share one 52-step restoring divider. A query
//    with a frequency table missing skips all of this and gives zeros with
//    found low.
//  - The result sits in an output register; the block goes back to idle once
//    it is loaded, so loads and the next query proceed while the receiver
//    stalls. A finished query waits only if the register is still full.
//  - Reset clears the config registers to defaults and the present flags;
//    table memories are not cleared and must be loaded before use.
`timescale 1ns / 1ps

module antenna_pcv_bilinear_interp #(
    parameter int MAX_ZEN_POINTS = 32,
    parameter int MAX_AZI_POINTS = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_mode,
    input  logic                i_freq_sel,
    input  logic [6:0]          i_azi_row,
    input  logic [4:0]          i_zen_col,
    input  logic signed [15:0]  i_pcv_value,
    input  logic [14:0]         i_zenith,
    input  logic [15:0]         i_azimuth,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [19:0]  o_pcv_first,
    output logic signed [19:0]  o_pcv_second,
    output logic                o_found
);
    import apbi_pkg::*;

    localparam int ZW = $clog2(MAX_ZEN_POINTS);
    localparam int AW = $clog2(MAX_AZI_POINTS);
    localparam logic [15:0] NZ_MAX = 16'(MAX_ZEN_POINTS);
    localparam logic [15:0] NA_MAX = 16'(MAX_AZI_POINTS);

    // configuration
    logic [14:0] r_zen_start, r_zen_step;
    logic [5:0]  r_zen_points;
    logic [15:0] r_azi_step;
    logic [7:0]  r_azi_points;

    t_state r_state, n_state;
    logic [1:0] r_present;

    // query datapath
    logic [14:0]             r_zen;
    logic [15:0]             r_azi;
    logic                    r_zgt, r_agt;
    logic [ZW-1:0]           r_k;
    logic [AW-1:0]           r_j;
    logic [ZW+14:0]          r_kbase;
    logic [AW+15:0]          r_jbase;
    logic signed [WGT_W-1:0] r_wz0, r_wz1, r_wa0, r_wa1;
    logic [3:0]              r_mask;
    logic [DIV_DW-1:0]       r_den;
    logic                    r_f;
    logic [2:0]              r_t;
    logic signed [2*WGT_W-1:0] r_p1_w;
    logic                    r_p1_vld;
    logic signed [ACC_W-1:0] r_p2;
    logic                    r_p2_vld;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_neg;
    logic signed [OUT_W-1:0] r_res0, r_res1;
    logic                    r_found_q;

    // output register
    logic                    r_o_valid;
    logic signed [OUT_W-1:0] r_o_first, r_o_second;
    logic                    r_o_found;

    // derived
    logic [14:0]  zs;
    logic         bil;
    logic [15:0]  zp16, ap16, nz, na, hi_z, hi_a, q16, k16;
    logic [ZW-1:0] k_next;
    logic [AW-1:0] j_next;
    logic         held;
    logic signed [31:0] dz32, da32;
    logic signed [WGT_W-1:0] dz, da, zs18, as18;
    logic [30:0]  den_bil;
    logic [1:0]   term;
    logic         issue;
    logic signed [WGT_W-1:0] wz_sel, wa_sel;
    logic [ACC_W-1:0] acc_mag;
    logic [DIV_NW-1:0] q;
    logic signed [OUT_W-1:0] sat;
    logic         in_acc, out_free, is_query, col_ok, row_ok, load_ok;

    // divider and tables
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quot;
    logic [DIV_DW-1:0] div_den;
    t_tbl_ctl          tbl_ctl;
    logic              tbl_f;
    logic [AW-1:0]     tbl_row;
    logic [ZW-1:0]     tbl_col;
    logic signed [VAL_W-1:0] tbl_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign is_query    = (i_mode == MODE_QUERY);
    assign out_free    = !r_o_valid || i_out_ready;

    assign col_ok  = ({27'd0, i_zen_col} < 32'(MAX_ZEN_POINTS));
    assign row_ok  = ({25'd0, i_azi_row} < 32'(MAX_AZI_POINTS));
    assign load_ok = col_ok && ((i_mode == MODE_LOAD_ZEN) ||
                                ((i_mode == MODE_LOAD_GRID) && row_ok));

    // grid geometry
    assign zs   = (r_zen_step == '0) ? 15'd1 : r_zen_step;
    assign bil  = (r_azi_step != '0);
    assign zp16 = 16'(r_zen_points);
    assign ap16 = 16'(r_azi_points);
    assign nz   = (zp16 < 16'd2) ? 16'd2 : ((zp16 > NZ_MAX) ? NZ_MAX : zp16);
    assign na   = (ap16 < 16'd2) ? 16'd2 : ((ap16 > NA_MAX) ? NA_MAX : ap16);
    assign hi_z = bil ? (nz - 16'd2) : (nz - 16'd1);
    assign hi_a = na - 16'd2;

    // lower cell index: floor((x - first - 1) / step), clamped to the last cell
    assign q16    = div_quot[15:0];
    assign k_next = !r_zgt ? '0 : ((q16 > hi_z) ? ZW'(hi_z) : ZW'(q16));
    assign j_next = !r_agt ? '0 : ((q16 > hi_a) ? AW'(hi_a) : AW'(q16));
    assign k16    = 16'(r_k);
    assign held   = !bil && (k16 == hi_z);

    // offsets inside the cell (negative below the first zenith point)
    assign dz32 = $signed({17'd0, r_zen}) - $signed({17'd0, r_zen_start})
                - $signed(32'(r_kbase));
    assign da32 = $signed({16'd0, r_azi}) - $signed(32'(r_jbase));
    assign dz   = dz32[WGT_W-1:0];
    assign da   = da32[WGT_W-1:0];
    assign zs18 = $signed({3'd0, zs});
    assign as18 = $signed({2'd0, r_azi_step});
    assign den_bil = zs * r_azi_step;

    // MAC term t: bit 0 picks zenith k / k+1, bit 1 azimuth j / j+1
    assign term   = r_t[1:0];
    assign issue  = (r_state == ST_MAC) && !r_t[2];
    assign wz_sel = term[0] ? r_wz1 : r_wz0;
    assign wa_sel = term[1] ? r_wa1 : r_wa0;

    assign acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    // round half away from zero already folded in; saturate and restore sign
    assign q = div_quot;
    always_comb begin
        if (r_neg) begin
            sat = (q > DIV_NW'(524288)) ? OUT_MIN : -$signed(q[OUT_W-1:0]);
        end else begin
            sat = (q > DIV_NW'(524287)) ? OUT_MAX : $signed(q[OUT_W-1:0]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = (r_present == 2'b11) ? ST_ZGO : ST_RES;
                end
            end
            ST_ZGO:   n_state = ST_ZWAIT;
            ST_ZWAIT: begin
                if (div_done) n_state = bil ? ST_AGO : ST_BASE;
            end
            ST_AGO:   n_state = ST_AWAIT;
            ST_AWAIT: begin
                if (div_done) n_state = ST_BASE;
            end
            ST_BASE:  n_state = ST_WGT;
            ST_WGT:   n_state = ST_MAC;
            ST_MAC: begin
                if (r_t == 3'd5) n_state = ST_QGO;
            end
            ST_QGO:   n_state = ST_QWAIT;
            ST_QWAIT: begin
                if (div_done) n_state = ST_SAT;
            end
            ST_SAT:   n_state = r_f ? ST_RES : ST_MAC;
            ST_RES: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // divider and table controls
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DIV_DW'(zs);
        tbl_ctl   = '0;
        tbl_f     = i_freq_sel;
        tbl_row   = AW'(i_azi_row);
        tbl_col   = ZW'(i_zen_col);
        unique case (r_state)
            ST_IDLE: begin
                tbl_ctl.we   = in_acc && load_ok;
                tbl_ctl.grid = (i_mode == MODE_LOAD_GRID);
            end
            ST_ZGO: begin
                div_start = 1'b1;
                div_num   = r_zgt ? DIV_NW'(r_zen - r_zen_start - 15'd1) : '0;
            end
            ST_AGO: begin
                div_start = 1'b1;
                div_num   = r_agt ? DIV_NW'(r_azi - 16'd1) : '0;
                div_den   = DIV_DW'(r_azi_step);
            end
            ST_MAC: begin
                tbl_ctl.re   = issue && r_mask[term];
                tbl_ctl.grid = bil;
                tbl_f        = r_f;
                tbl_row      = r_j + AW'(term[1]);
                tbl_col      = r_k + ZW'(term[0]);
            end
            ST_QGO: begin
                div_start = 1'b1;
                div_num   = acc_mag + DIV_NW'(r_den >> 1);
                div_den   = r_den;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_present    <= '0;
            r_o_valid    <= 1'b0;
            r_zen_start  <= 15'd0;
            r_zen_step   <= 15'd500;
            r_zen_points <= 6'd19;
            r_azi_step   <= 16'd0;
            r_azi_points <= 8'd0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= issue && r_mask[term];
            r_p2_vld <= r_p1_vld;
            if (in_acc && load_ok) begin
                r_present[i_freq_sel] <= 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ZEN_START:  r_zen_start  <= i_cfg_data[14:0];
                    CFG_ZEN_STEP:   r_zen_step   <= i_cfg_data[14:0];
                    CFG_ZEN_POINTS: r_zen_points <= i_cfg_data[5:0];
                    CFG_AZI_STEP:   r_azi_step   <= i_cfg_data;
                    CFG_AZI_POINTS: r_azi_points <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_RES) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && is_query) begin
            r_zen     <= i_zenith;
            r_azi     <= i_azimuth;
            r_zgt     <= (i_zenith > r_zen_start);
            r_agt     <= (i_azimuth != '0);
            r_j       <= '0;
            r_found_q <= (r_present == 2'b11);
            r_res0    <= '0;
            r_res1    <= '0;
        end
        if ((r_state == ST_ZWAIT) && div_done) r_k <= k_next;
        if ((r_state == ST_AWAIT) && div_done) r_j <= j_next;
        if (r_state == ST_BASE) begin
            r_kbase <= r_k * zs;
            r_jbase <= r_j * r_azi_step;
        end
        if (r_state == ST_WGT) begin
            r_f   <= 1'b0;
            r_t   <= '0;
            r_acc <= '0;
            if (bil) begin
                r_wz0  <= zs18 - dz;
                r_wz1  <= dz;
                r_wa0  <= as18 - da;
                r_wa1  <= da;
                r_mask <= 4'b1111;
                r_den  <= DIV_DW'(den_bil);
            end else if (held) begin
                r_wz0  <= 18'sd1;
                r_wz1  <= '0;
                r_wa0  <= 18'sd1;
                r_wa1  <= '0;
                r_mask <= 4'b0001;
                r_den  <= DIV_DW'(1);
            end else begin
                r_wz0  <= zs18 - dz;
                r_wz1  <= dz;
                r_wa0  <= 18'sd1;
                r_wa1  <= '0;
                r_mask <= 4'b0011;
                r_den  <= DIV_DW'(zs);
            end
        end
        if (r_state == ST_MAC) r_t <= r_t + 3'd1;
        // weight -> value product -> accumulate, one register per step
        r_p1_w <= wz_sel * wa_sel;
        if (r_p1_vld) r_p2 <= tbl_rdata * r_p1_w;
        if (r_p2_vld) r_acc <= r_acc + r_p2;
        if (r_state == ST_QGO) r_neg <= r_acc[ACC_W-1];
        if (r_state == ST_SAT) begin
            if (!r_f) begin
                r_res0 <= sat;
                r_f    <= 1'b1;
                r_t    <= '0;
                r_acc  <= '0;
            end else begin
                r_res1 <= sat;
            end
        end
        if ((r_state == ST_RES) && out_free) begin
            r_o_first  <= r_res0;
            r_o_second <= r_res1;
            r_o_found  <= r_found_q;
        end
    end

    apbi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    apbi_tables #(
        .ZW (ZW),
        .AW (AW)
    ) u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tbl_ctl),
        .i_f     (tbl_f),
        .i_row   (tbl_row),
        .i_col   (tbl_col),
        .i_wdata (i_pcv_value),
        .o_rdata (tbl_rdata)
    );

    assign o_out_valid  = r_o_valid;
    assign o_pcv_first  = r_o_first;
    assign o_pcv_second = r_o_second;
    assign o_found      = r_o_found;

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_pcv_first == '0 && o_pcv_second == '0))
        else $error("not-found result carries nonzero values");
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_ZWAIT || r_state == ST_AWAIT ||
                      r_state == ST_QWAIT))
        else $error("divider finished outside a wait state");
    a_absent_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_query && r_present != 2'b11) |=>
            (r_state == ST_RES && !r_found_q))
        else $error("query with a missing table did not short-cut");

endmodule

@@ sim/apbi_checker.sv @@
// Scoreboard for the antenna PCV interpolator: watches the config, input and output channels.
// Predicts each query result from its own copy of the tables and compares; depends on apbi_pkg.
`timescale 1ns / 1ps

module apbi_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_mode,
    input  logic               i_freq_sel,
    input  logic [6:0]         i_azi_row,
    input  logic [4:0]         i_zen_col,
    input  logic signed [15:0] i_pcv_value,
    input  logic [14:0]        i_zenith,
    input  logic [15:0]        i_azimuth,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [19:0] i_pcv_first,
    input  logic signed [19:0] i_pcv_second,
    input  logic               i_found,
    output int                 o_errors,
    output int                 o_pending
);
    import apbi_pkg::*;

    typedef struct {
        logic signed [19:0] first;
        logic signed [19:0] second;
        logic               found;
    } t_pcv_result;

    logic signed [15:0] grid_tbl [2][128][32];
    logic signed [15:0] zen_tbl  [2][32];
    logic [1:0]         present;
    logic [14:0]        zen_start, zen_step;
    logic [5:0]         zen_points;
    logic [15:0]        azi_step;
    logic [7:0]         azi_points;
    t_pcv_result        pcv_queue [$];

    assign o_pending = pcv_queue.size();

    function automatic longint cell_below(longint x, longint first, longint step,
                                          longint n, longint hi);
        longint c;
        c = 0;
        if (x > first) begin
            c = (x - first + step - 1) / step;
            if (c > n) c = n;
        end
        c = c - 1;
        if (c < 0) c = 0;
        if (c > hi) c = hi;
        return c;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [19:0] clip(longint v);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[19:0];
    endfunction

    function automatic longint interp_pcv(int f, longint zen, longint azi);
        longint zs, nz, z0, as, na, k, j, dz, da, num;
        zs = (zen_step == 0) ? 1 : zen_step;
        nz = zen_points;
        z0 = zen_start;
        if (nz < 2) nz = 2;
        if (nz > 32) nz = 32;
        if (azi_step == 0) begin
            k = cell_below(zen, z0, zs, nz, nz - 1);
            if (k >= nz - 1) return longint'(zen_tbl[f][k]);
            dz = zen - (z0 + k * zs);
            return round_div(longint'(zen_tbl[f][k]) * (zs - dz)
                             + longint'(zen_tbl[f][k+1]) * dz, zs);
        end
        as = azi_step;
        na = azi_points;
        if (na < 2) na = 2;
        if (na > 128) na = 128;
        k = cell_below(zen, z0, zs, nz, nz - 2);
        j = cell_below(azi, 0, as, na, na - 2);
        dz = zen - (z0 + k * zs);
        da = azi - j * as;
        num = longint'(grid_tbl[f][j][k]) * (zs - dz) * (as - da)
            + longint'(grid_tbl[f][j][k+1]) * dz * (as - da)
            + longint'(grid_tbl[f][j+1][k]) * (zs - dz) * da
            + longint'(grid_tbl[f][j+1][k+1]) * dz * da;
        return round_div(num, zs * as);
    endfunction

    always @(posedge i_clk) begin
        t_pcv_result exp_res;
        int          err_cnt;
        err_cnt = 0;
        if (!i_rst_n) begin
            present    <= 2'b00;
            zen_start  <= 15'd0;
            zen_step   <= 15'd500;
            zen_points <= 6'd19;
            azi_step   <= 16'd0;
            azi_points <= 8'd0;
            o_errors   <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ZEN_START:  zen_start  <= i_cfg_data[14:0];
                    CFG_ZEN_STEP:   zen_step   <= i_cfg_data[14:0];
                    CFG_ZEN_POINTS: zen_points <= i_cfg_data[5:0];
                    CFG_AZI_STEP:   azi_step   <= i_cfg_data;
                    CFG_AZI_POINTS: azi_points <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_mode)
                    MODE_LOAD_ZEN: begin
                        zen_tbl[i_freq_sel][i_zen_col] = i_pcv_value;
                        present[i_freq_sel] <= 1'b1;
                    end
                    MODE_LOAD_GRID: begin
                        grid_tbl[i_freq_sel][i_azi_row][i_zen_col] = i_pcv_value;
                        present[i_freq_sel] <= 1'b1;
                    end
                    MODE_QUERY: begin
                        if (present != 2'b11) begin
                            exp_res = '{first: '0, second: '0, found: 1'b0};
                        end else begin
                            exp_res.first  = clip(interp_pcv(0, i_zenith, i_azimuth));
                            exp_res.second = clip(interp_pcv(1, i_zenith, i_azimuth));
                            exp_res.found  = 1'b1;
                        end
                        pcv_queue.push_back(exp_res);
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pcv_queue.size() == 0) begin
                    $error("result transaction with no query pending");
                    err_cnt++;
                end else begin
                    exp_res = pcv_queue.pop_front();
                    if (i_pcv_first !== exp_res.first) begin
                        $error("pcv_first: expected %0d, got %0d", exp_res.first, i_pcv_first);
                        err_cnt++;
                    end
                    if (i_pcv_second !== exp_res.second) begin
                        $error("pcv_second: expected %0d, got %0d",
                               exp_res.second, i_pcv_second);
                        err_cnt++;
                    end
                    if (i_found !== exp_res.found) begin
                        $error("found: expected %0b, got %0b", exp_res.found, i_found);
                        err_cnt++;
                    end
                end
            end
            o_errors <= o_errors + err_cnt;
        end
    end

endmodule

@@ sim/testbench.sv @@
// Top of the antenna PCV interpolator testbench: clock, reset, stimulus and verdict.
// Depends on apbi_pkg, the block itself and apbi_checker.
`timescale 1ns / 1ps

module testbench;
    import apbi_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_ITEMS  = 850;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         mode = '0;
    logic               freq_sel = 1'b0;
    logic [6:0]         azi_row = '0;
    logic [4:0]         zen_col = '0;
    logic signed [15:0] pcv_value = '0;
    logic [14:0]        zenith = '0;
    logic [15:0]        azimuth = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [19:0] pcv_first, pcv_second;
    logic               found;
    int                 errors, pending;

    // idle percentages of each side, and the long receiver hold-off
    int  tx_idle = 21;
    int  rx_idle = 78;
    bit  hold_req = 1'b0;
    bit  rx_hold = 1'b0;
    int  cycles = 0;

    // shadow of the config registers, used to pick reachable table entries
    int  sh_z0 = 0, sh_zs = 500, sh_nz = 19, sh_as = 0, sh_na = 0;
    int  col_max, row_max;
    bit  zen_written  [2][32];
    bit  grid_written [2][128][32];

    antenna_pcv_bilinear_interp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_mode(mode), .i_freq_sel(freq_sel), .i_azi_row(azi_row),
        .i_zen_col(zen_col), .i_pcv_value(pcv_value),
        .i_zenith(zenith), .i_azimuth(azimuth),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_pcv_first(pcv_first), .o_pcv_second(pcv_second), .o_found(found)
    );

    apbi_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_mode(mode), .i_freq_sel(freq_sel), .i_azi_row(azi_row),
        .i_zen_col(zen_col), .i_pcv_value(pcv_value),
        .i_zenith(zenith), .i_azimuth(azimuth),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_pcv_first(pcv_first), .i_pcv_second(pcv_second), .i_found(found),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off counted here
    always @(negedge i_clk) begin
        out_ready = !rx_hold && ($urandom_range(99) >= rx_idle);
    end

    initial begin
        @(posedge hold_req);
        rx_hold = 1'b1;
        repeat (3000) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    // same cell search as the block: index of the lower grid point
    function automatic int cell_below(int x, int first, int step, int n, int hi);
        int c;
        c = 0;
        if (x > first) begin
            c = (x - first + step - 1) / step;
            if (c > n) c = n;
        end
        c = c - 1;
        if (c < 0) c = 0;
        if (c > hi) c = hi;
        return c;
    endfunction

    task automatic cfg_write(logic [2:0] idx, int value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value[15:0];
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        case (idx)
            CFG_ZEN_START:  sh_z0 = value;
            CFG_ZEN_STEP:   sh_zs = value;
            CFG_ZEN_POINTS: sh_nz = value;
            CFG_AZI_STEP:   sh_as = value;
            CFG_AZI_POINTS: sh_na = value;
            default: ;
        endcase
    endtask

    // one input transaction; unused fields carry random bits
    task automatic send_item(logic [1:0] m, logic f, int row, int col, int val,
                             int zen, int azi);
        while ($urandom_range(99) < tx_idle) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid  = 1'b1;
        mode      = m;
        freq_sel  = f;
        azi_row   = row[6:0];
        zen_col   = col[4:0];
        pcv_value = val[15:0];
        zenith    = zen[14:0];
        azimuth   = azi[15:0];
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    function automatic int rand_val();
        case ($urandom_range(9))
            0:       return 32767;
            1:       return -32768;
            default: return $urandom_range(65535) - 32768;
        endcase
    endfunction

    task automatic load(logic [1:0] m, logic f, int row, int col, int val);
        send_item(m, f, row, col, val, $urandom_range(18000), $urandom_range(36000));
        if (m == MODE_LOAD_ZEN) zen_written[f][col] = 1'b1;
        else grid_written[f][row][col] = 1'b1;
    endtask

    task automatic query(int zen, int azi);
        send_item(MODE_QUERY, $urandom_range(1), $urandom_range(127), $urandom_range(31),
                  rand_val(), zen, azi);
    endtask

    // Load every entry a query can reach under the current config, so that
    // no query ever reads an entry that was never written.
    task automatic fill_reachable();
        int zs, nz, na;
        zs = (sh_zs == 0) ? 1 : sh_zs;
        nz = (sh_nz < 2) ? 2 : (sh_nz > 32) ? 32 : sh_nz;
        na = (sh_na < 2) ? 2 : (sh_na > 128) ? 128 : sh_na;
        if (sh_as == 0) begin
            col_max = cell_below(18000, sh_z0, zs, nz, nz - 1) + 1;
            if (col_max > nz - 1) col_max = nz - 1;
            row_max = 0;
        end else begin
            col_max = cell_below(18000, sh_z0, zs, nz, nz - 2) + 1;
            row_max = cell_below(36000, 0, sh_as, na, na - 2) + 1;
        end
        for (int f = 0; f < 2; f++)
            for (int r = 0; r <= row_max; r++)
                for (int c = 0; c <= col_max; c++) begin
                    if (sh_as == 0 && !zen_written[f][c])
                        load(MODE_LOAD_ZEN, f, r, c, rand_val());
                    if (sh_as != 0 && !grid_written[f][r][c])
                        load(MODE_LOAD_GRID, f, r, c, rand_val());
                end
    endtask

    // wait for every result, then wait out a trailing load
    task automatic settle();
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int pick_zen();
        int zs;
        zs = (sh_zs == 0) ? 1 : sh_zs;
        case ($urandom_range(9))
            0: return 0;
            1: return 18000;
            2: return (sh_z0 > 18000) ? 18000 : sh_z0;
            3: return (sh_z0 + $urandom_range(8) * zs) % 18001;
            4: return 16384 + $urandom_range(1616);
            default: return $urandom_range(18000);
        endcase
    endfunction

    function automatic int pick_azi();
        case ($urandom_range(9))
            0: return 0;
            1: return 36000;
            2: return (sh_as * $urandom_range(4)) % 36001;
            3: return 32768 + $urandom_range(3232);
            default: return $urandom_range(36000);
        endcase
    endfunction

    int phase_cfg [7][5] = '{
        '{0,     500,   19, 0,     0},
        '{1000,  1000,  8,  0,     0},
        '{0,     18000, 32, 36000, 128},
        '{17990, 0,     4,  0,     0},
        '{0,     3000,  7,  6000,  7},
        '{9000,  2000,  0,  5000,  255},
        '{500,   1500,  10, 4500,  9}
    };

    initial begin
        int done_items;
        int pick;
        done_items = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: no table present, an ignored mode, one table only
        query(9000, 0);
        send_item(MODE_IGNORED, 1'b1, 127, 31, -1, 32767, 65535);
        load(MODE_LOAD_ZEN, 1'b0, 0, 0, 32767);
        query(0, 0);
        load(MODE_LOAD_ZEN, 1'b1, 0, 0, -32768);
        fill_reachable();
        query(0, 0);
        query(18000, 36000);     // past the last zenith point: held value
        query(250, 0);
        query(16384, 32768);

        for (int p = 0; p < 7; p++) begin
            settle();
            cfg_write(CFG_ZEN_START,  phase_cfg[p][0]);
            cfg_write(CFG_ZEN_STEP,   phase_cfg[p][1]);
            cfg_write(CFG_ZEN_POINTS, phase_cfg[p][2]);
            cfg_write(CFG_AZI_STEP,   phase_cfg[p][3]);
            cfg_write(CFG_AZI_POINTS, phase_cfg[p][4]);
            fill_reachable();
            for (int i = 0; i < RAND_ITEMS / 7; i++) begin
                // idling schedule over the whole random run
                if (done_items < RAND_ITEMS / 3) begin
                    tx_idle = 21; rx_idle = 78;
                end else if (done_items < 2 * RAND_ITEMS / 3) begin
                    tx_idle = 78; rx_idle = 21;
                end else begin
                    tx_idle = 0; rx_idle = 0;
                end
                if (done_items == 150) hold_req = 1'b1;
                pick = $urandom_range(99);
                if (pick < 70) begin
                    query(pick_zen(), pick_azi());
                end else if (pick < 88) begin
                    if (sh_as == 0)
                        load(MODE_LOAD_ZEN, $urandom_range(1), $urandom_range(127),
                             $urandom_range(col_max), rand_val());
                    else
                        load(MODE_LOAD_GRID, $urandom_range(1), $urandom_range(row_max),
                             $urandom_range(col_max), rand_val());
                end else if (pick < 96) begin
                    // writes outside the reachable region are harmless
                    load($urandom_range(1), $urandom_range(1), $urandom_range(127),
                         $urandom_range(31), rand_val());
                end else begin
                    send_item(MODE_IGNORED, $urandom_range(1), $urandom_range(127),
                              $urandom_range(31), rand_val(), $urandom_range(32767),
                              $urandom_range(65535));
                    i--;
                end
                done_items++;
            end
        end

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/apbi_pkg.sv
sv/apbi_div.sv
sv/apbi_tables.sv
sv/antenna_pcv_bilinear_interp.sv
sim/apbi_checker.sv
sim/testbench.sv
